// ===== rtl/bct_pkg.sv =====
// ----------------------------------------------------------------------------
// bct_pkg
// Shared types and codes for the block congruence transform unit.
// ----------------------------------------------------------------------------
package bct_pkg;

    // APB configuration port geometry: three 48-bit rows at 8-byte spacing
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_LSB = 3;

    // Item kinds carried on the cmd field
    localparam logic CMD_FORCE = 1'b0;
    localparam logic CMD_STIFF = 1'b1;

    typedef enum logic [1:0] {
        REG_T_ROW0 = 2'd0,
        REG_T_ROW1 = 2'd1,
        REG_T_ROW2 = 2'd2
    } t_reg_idx;

    // Control word that travels with each transaction through the pipeline
    typedef struct packed {
        logic valid;
        logic cmd;
        logic last;
    } t_pipe_ctl;

endpackage

// ===== rtl/bct_regs.sv =====
// ----------------------------------------------------------------------------
// bct_regs
// APB register file holding the three rows of the transform matrix T.
// ----------------------------------------------------------------------------
module bct_regs #(
    parameter int COEF_WIDTH = 16,
    localparam int ROW_W = 3 * COEF_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [bct_pkg::APB_ADDR_W-1:0]      i_paddr,
    input  logic [bct_pkg::APB_DATA_W-1:0]      i_pwdata,
    output logic [bct_pkg::APB_DATA_W-1:0]      o_prdata,
    output logic                                o_pready,
    output logic [2:0][ROW_W-1:0]               o_t_row
);
    import bct_pkg::*;

    localparam int FRAC = COEF_WIDTH - 2;
    localparam logic [ROW_W-1:0] ONE = ROW_W'(1) << FRAC;

    logic [2:0][ROW_W-1:0]            r_t_row;
    logic [ROW_W+APB_DATA_W-1:0]      wr_ext;
    logic [ROW_W-1:0]                 wr_row;
    logic [APB_DATA_W+ROW_W-1:0]      rd_ext;
    logic [ROW_W-1:0]                 rd_row;
    logic                             wr_en;
    t_reg_idx                         idx;

    assign idx    = t_reg_idx'(i_paddr[APB_ADDR_W-1:REG_IDX_LSB]);
    assign wr_en  = i_psel & i_penable & i_pwrite;
    assign wr_ext = {ROW_W'(0), i_pwdata};
    assign wr_row = wr_ext[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_row[0] <= ONE;
            r_t_row[1] <= ONE << COEF_WIDTH;
            r_t_row[2] <= ONE << (2 * COEF_WIDTH);
        end else if (wr_en) begin
            unique case (idx)
                REG_T_ROW0: r_t_row[0] <= wr_row;
                REG_T_ROW1: r_t_row[1] <= wr_row;
                REG_T_ROW2: r_t_row[2] <= wr_row;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_T_ROW0: rd_row = r_t_row[0];
            REG_T_ROW1: rd_row = r_t_row[1];
            REG_T_ROW2: rd_row = r_t_row[2];
            default:    rd_row = '0;
        endcase
    end

    assign rd_ext   = {APB_DATA_W'(0), rd_row};
    assign o_prdata = rd_ext[APB_DATA_W-1:0];
    assign o_pready = 1'b1;
    assign o_t_row  = r_t_row;

endmodule

// ===== rtl/bct_kt.sv =====
// ----------------------------------------------------------------------------
// bct_kt
// First half of the pipeline: M = K T with one rounding (multiply, then
// sum and round). Force items bypass the product and pass f in column 0.
// ----------------------------------------------------------------------------
module bct_kt #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_WIDTH = 16,
    localparam int M_WIDTH = DATA_WIDTH + 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bct_pkg::t_pipe_ctl                   i_ctl,
    output logic                                 o_ready,
    input  logic [8:0][DATA_WIDTH-1:0]           i_elem,
    input  logic [2:0][3*COEF_WIDTH-1:0]         i_t_row,
    output bct_pkg::t_pipe_ctl                   o_ctl,
    input  logic                                 i_ready,
    output logic [2:0][2:0][M_WIDTH-1:0]         o_m
);
    import bct_pkg::*;

    localparam int P_W  = DATA_WIDTH + COEF_WIDTH;
    localparam int S_W  = P_W + 2;
    localparam int FRAC = COEF_WIDTH - 2;
    localparam logic [S_W-1:0] HALF = S_W'(1) << (FRAC - 1);

    logic signed [COEF_WIDTH-1:0]        coef [3][3];
    logic [2:0][2:0][2:0][P_W-1:0]       n_a_prod, r_a_prod;
    logic [2:0][DATA_WIDTH-1:0]          r_a_force;
    t_pipe_ctl                           r_a_ctl, r_b_ctl;
    logic [2:0][2:0][M_WIDTH-1:0]        n_b_m, r_b_m;
    logic signed [S_W-1:0]               sum [3][3];
    logic a_ready, b_ready;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = i_t_row[r][c*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    assign b_ready = !r_b_ctl.valid || i_ready;
    assign a_ready = !r_a_ctl.valid || b_ready;

    // Stage A: products e[k][l] * t[l][j]
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                for (int l = 0; l < 3; l++) begin
                    n_a_prod[k][j][l] = $signed(i_elem[3*k+l]) * coef[l][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (a_ready) begin
            r_a_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_prod  <= n_a_prod;
            r_a_force <= i_elem[2:0];
        end
    end

    // Stage B: sum of three, round half up
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                sum[k][j] = S_W'($signed(r_a_prod[k][j][0]))
                          + S_W'($signed(r_a_prod[k][j][1]))
                          + S_W'($signed(r_a_prod[k][j][2]))
                          + $signed(HALF);
                if (r_a_ctl.cmd == CMD_FORCE) begin
                    n_b_m[k][j] = (j == 0) ? M_WIDTH'($signed(r_a_force[k])) : '0;
                end else begin
                    n_b_m[k][j] = sum[k][j][S_W-1:FRAC];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (b_ready) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready) begin
            r_b_m <= n_b_m;
        end
    end

    assign o_ready = a_ready;
    assign o_ctl   = r_b_ctl;
    assign o_m     = r_b_m;

endmodule

// ===== rtl/bct_tm.sv =====
// ----------------------------------------------------------------------------
// bct_tm
// Second half of the pipeline: R = T' M, rounded and saturated, held in the
// output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module bct_tm #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_WIDTH = 16,
    localparam int M_WIDTH = DATA_WIDTH + 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bct_pkg::t_pipe_ctl                   i_ctl,
    output logic                                 o_ready,
    input  logic [2:0][2:0][M_WIDTH-1:0]         i_m,
    input  logic [2:0][3*COEF_WIDTH-1:0]         i_t_row,
    output bct_pkg::t_pipe_ctl                   o_ctl,
    input  logic                                 i_ready,
    output logic [8:0][DATA_WIDTH-1:0]           o_res,
    output logic                                 o_overflow
);
    import bct_pkg::*;

    localparam int Q_W  = M_WIDTH + COEF_WIDTH;
    localparam int S_W  = Q_W + 2;
    localparam int FRAC = COEF_WIDTH - 2;
    localparam int V_W  = S_W - FRAC;
    localparam logic [S_W-1:0]        HALF = S_W'(1) << (FRAC - 1);
    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic signed [COEF_WIDTH-1:0]        coef [3][3];
    logic [2:0][2:0][2:0][Q_W-1:0]       n_c_prod, r_c_prod;
    t_pipe_ctl                           r_c_ctl, r_d_ctl;
    logic signed [S_W-1:0]               sum [3][3];
    logic [V_W-1:0]                      val [3][3];
    logic [DATA_WIDTH-1:0]               sat [3][3];
    logic [2:0][2:0]                     clip;
    logic [8:0][DATA_WIDTH-1:0]          n_d_res, r_d_res;
    logic                                n_d_ovf, r_d_ovf;
    logic c_ready, d_ready;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r][c] = i_t_row[r][c*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    assign d_ready = !r_d_ctl.valid || i_ready;
    assign c_ready = !r_c_ctl.valid || d_ready;

    // Stage C: products t[k][i] * m[k][j]
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    n_c_prod[i][j][k] = coef[k][i] * $signed(i_m[k][j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_ctl <= '0;
        end else if (c_ready) begin
            r_c_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_ready) begin
            r_c_prod <= n_c_prod;
        end
    end

    // Stage D: sum, round, clamp, then place per item kind
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                sum[i][j] = S_W'($signed(r_c_prod[i][j][0]))
                          + S_W'($signed(r_c_prod[i][j][1]))
                          + S_W'($signed(r_c_prod[i][j][2]))
                          + $signed(HALF);
                val[i][j]  = sum[i][j][S_W-1:FRAC];
                clip[i][j] = !((&val[i][j][V_W-1:DATA_WIDTH-1]) ||
                               !(|val[i][j][V_W-1:DATA_WIDTH-1]));
                if (clip[i][j]) begin
                    sat[i][j] = val[i][j][V_W-1] ? SAT_MIN : SAT_MAX;
                end else begin
                    sat[i][j] = val[i][j][DATA_WIDTH-1:0];
                end
            end
        end

        n_d_res = '0;
        if (r_c_ctl.cmd == CMD_FORCE) begin
            for (int j = 0; j < 3; j++) begin
                n_d_res[j] = sat[j][0];
            end
            n_d_ovf = clip[0][0] | clip[1][0] | clip[2][0];
        end else begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    n_d_res[3*i+j] = sat[i][j];
                end
            end
            n_d_ovf = |clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl <= '0;
        end else if (d_ready) begin
            r_d_ctl <= r_c_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_ready) begin
            r_d_res <= n_d_res;
            r_d_ovf <= n_d_ovf;
        end
    end

    assign o_ready    = c_ready;
    assign o_ctl      = r_d_ctl;
    assign o_res      = r_d_res;
    assign o_overflow = r_d_ovf;

endmodule

// ===== rtl/block_congruence_transform_unit.sv =====
// Throughput: one transaction per cycle while i_stall is low; four register stages
//   (two multiply, two sum/round) each advance independently, so bubbles
//   collapse under output stall.
// Reset (synchronous, active low) empties every stage and loads T with identity.
// ----------------------------------------------------------------------------
// block_congruence_transform_unit
// Rotates finite-element data from local to global axes with a configured
// 3x3 matrix T: force triples give T'f, stiffness blocks give T'KT.
// ----------------------------------------------------------------------------
module block_congruence_transform_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bct_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [bct_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bct_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // Input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic signed [DATA_WIDTH-1:0]        i_e0,
    input  logic signed [DATA_WIDTH-1:0]        i_e1,
    input  logic signed [DATA_WIDTH-1:0]        i_e2,
    input  logic signed [DATA_WIDTH-1:0]        i_e3,
    input  logic signed [DATA_WIDTH-1:0]        i_e4,
    input  logic signed [DATA_WIDTH-1:0]        i_e5,
    input  logic signed [DATA_WIDTH-1:0]        i_e6,
    input  logic signed [DATA_WIDTH-1:0]        i_e7,
    input  logic signed [DATA_WIDTH-1:0]        i_e8,
    input  logic                                i_last_block,
    // Output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [DATA_WIDTH-1:0]        o_r0,
    output logic signed [DATA_WIDTH-1:0]        o_r1,
    output logic signed [DATA_WIDTH-1:0]        o_r2,
    output logic signed [DATA_WIDTH-1:0]        o_r3,
    output logic signed [DATA_WIDTH-1:0]        o_r4,
    output logic signed [DATA_WIDTH-1:0]        o_r5,
    output logic signed [DATA_WIDTH-1:0]        o_r6,
    output logic signed [DATA_WIDTH-1:0]        o_r7,
    output logic signed [DATA_WIDTH-1:0]        o_r8,
    output logic                                o_overflow,
    output logic                                o_last
);
    import bct_pkg::*;

    localparam int ROW_W   = 3 * COEF_WIDTH;
    localparam int M_WIDTH = DATA_WIDTH + 4;

    logic [2:0][ROW_W-1:0]              t_row;
    logic [8:0][DATA_WIDTH-1:0]         elem;
    logic [2:0][2:0][M_WIDTH-1:0]       kt_m;
    logic [8:0][DATA_WIDTH-1:0]         res;
    t_pipe_ctl                          in_ctl, kt_ctl, out_ctl;
    logic                               kt_ready, tm_ready, res_ovf;

    // Matrix T lives in the register file; the user must write it only while
    // idle (the block does not enforce this), so every stage reads it live.
    bct_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (prdata),
        .o_pready   (pready),
        .o_t_row    (t_row)
    );

    // Gather the input transaction into one word for the pipeline.
    assign elem = {i_e8, i_e7, i_e6, i_e5, i_e4, i_e3, i_e2, i_e1, i_e0};
    assign in_ctl.valid = i_valid;
    assign in_ctl.cmd   = i_cmd;
    assign in_ctl.last  = i_last_block;

    // Stages A and B: M = K T (force items pass f through as column 0).
    bct_kt #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_kt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (in_ctl),
        .o_ready    (kt_ready),
        .i_elem     (elem),
        .i_t_row    (t_row),
        .o_ctl      (kt_ctl),
        .i_ready    (tm_ready),
        .o_m        (kt_m)
    );

    // Stages C and D: R = T' M, rounded and saturated; stage D is the
    // output register, so a waiting result never blocks upstream bubbles.
    bct_tm #(
        .DATA_WIDTH (DATA_WIDTH),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_tm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (kt_ctl),
        .o_ready    (tm_ready),
        .i_m        (kt_m),
        .i_t_row    (t_row),
        .o_ctl      (out_ctl),
        .i_ready    (!i_stall),
        .o_res      (res),
        .o_overflow (res_ovf)
    );

    // Stall upstream only when stage A is full and cannot advance.
    assign o_stall    = !kt_ready;

    assign o_valid    = out_ctl.valid;
    assign o_last     = out_ctl.last;
    assign o_overflow = res_ovf;
    assign o_r0 = res[0];
    assign o_r1 = res[1];
    assign o_r2 = res[2];
    assign o_r3 = res[3];
    assign o_r4 = res[4];
    assign o_r5 = res[5];
    assign o_r6 = res[6];
    assign o_r7 = res[7];
    assign o_r8 = res[8];

`ifndef SYNTH
    localparam logic [DATA_WIDTH-1:0] CHK_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] CHK_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    logic [8:0] chk_at_bound;

    always_comb begin
        for (int n = 0; n < 9; n++) begin
            chk_at_bound[n] = (res[n] == CHK_MAX) || (res[n] == CHK_MIN);
        end
    end

    // A free output side lets the whole pipeline advance.
    a_no_stall_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output side is free");

    // Force results carry nothing beyond the first three elements.
    a_force_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && out_ctl.cmd == CMD_FORCE) |->
            (res[8:3] == '0))
        else $error("force result has nonzero upper elements");

    // An overflow flag means some element sits at a saturation bound.
    a_ovf_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (|chk_at_bound))
        else $error("overflow flagged with no saturated element");

    // An item accepted while the output is free passes stage A and reaches stage B, provided the output stays free.
    a_stage_b_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_stall) ##1 !i_stall |=> kt_ctl.valid)
        else $error("accepted item lost in first half of pipeline");
`endif

endmodule
